@@ design/pdp_pkg.sv @@
package pdp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF  = 16;

  // Fraction bits added below the coordinate LSB inside the CORDIC datapath.
  localparam int GUARD       = 8;
  localparam int ANGLE_WIDTH = 16;
  localparam int Z_WIDTH     = 32;
  localparam int ATAN_LEN    = 24;
  localparam int ATAN_IDX_W  = 5;

  // Inverse CORDIC gain in Q30 and the split used for the gain multiply.
  localparam int GAIN_WIDTH = 30;
  localparam logic [GAIN_WIDTH-1:0] INV_GAIN = 30'd652032874;
  localparam int LO_WIDTH   = 22;
  localparam int RND_SHIFT  = 29 + GUARD;
  localparam int FIN_SHIFT  = GUARD + 8;

  localparam logic [Z_WIDTH-1:0] Z_QUARTER     = 32'h4000_0000;
  localparam logic [Z_WIDTH-1:0] Z_NEG_QUARTER = 32'hC000_0000;
  localparam logic [Z_WIDTH-1:0] DIR_ROUND     = 32'h0000_8000;

  typedef struct packed {
    logic valid;
    logic zero;
  } pdp_ctl_t;

  // atan(2^-i) with 2^31 = pi, rounded to nearest.
  function automatic logic [Z_WIDTH-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [Z_WIDTH-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10680350;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ design/pdp_if.sv @@
interface pdp_in_if import pdp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface pdp_out_if import pdp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH:0]   magnitude;
  logic signed [ANGLE_WIDTH-1:0] direction;

  modport source (output valid, magnitude, direction, input ready);
  modport sink   (input valid, magnitude, direction, output ready);
endinterface

@@ design/pdp_front.sv @@
module pdp_front import pdp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DW          = COORD_WIDTH_DEF + 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    ld,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  output logic                          vld0_o,
  output pdp_ctl_t                      ctl_o,
  output logic signed [DW-1:0]          x_o,
  output logic signed [DW-1:0]          y_o,
  output logic [Z_WIDTH-1:0]            z_o
);

  logic                          vld0_r;
  logic signed [COORD_WIDTH:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  pdp_ctl_t                      ctl_r, ctl_nxt;
  logic signed [DW-1:0]          x_r, y_r, x_nxt, y_nxt, xg, yg;
  logic [Z_WIDTH-1:0]            z_r, z_nxt;

  // Stage 0: exact differences, one bit wider than a coordinate.
  always_comb begin
    dx_nxt = (COORD_WIDTH+1)'(first_x) - (COORD_WIDTH+1)'(second_x);
    dy_nxt = (COORD_WIDTH+1)'(first_y) - (COORD_WIDTH+1)'(second_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (ld[0]) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // Stage 1: scale up and rotate the left half plane onto the right one.
  always_comb begin
    xg = DW'(dx_r) <<< GUARD;
    yg = DW'(dy_r) <<< GUARD;
    ctl_nxt.valid = vld0_r;
    ctl_nxt.zero  = (dx_r == '0) && (dy_r == '0);
    if (dx_r[COORD_WIDTH]) begin
      if (!dy_r[COORD_WIDTH]) begin
        x_nxt = yg;
        y_nxt = -xg;
        z_nxt = Z_QUARTER;
      end else begin
        x_nxt = -yg;
        y_nxt = xg;
        z_nxt = Z_NEG_QUARTER;
      end
    end else begin
      x_nxt = xg;
      y_nxt = yg;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ld[1]) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign vld0_o = vld0_r;
  assign ctl_o  = ctl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

@@ design/pdp_cordic_stage.sv @@
module pdp_cordic_stage import pdp_pkg::*; #(
  parameter int DW    = COORD_WIDTH_DEF + 11,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld,
  input  pdp_ctl_t             ctl_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic [Z_WIDTH-1:0]   z_i,
  output pdp_ctl_t             ctl_o,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output logic [Z_WIDTH-1:0]   z_o
);

  pdp_ctl_t             ctl_r;
  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic [Z_WIDTH-1:0]   z_r, z_nxt, step;

  // One micro-rotation driving y toward zero; both updates use the old x and y.
  always_comb begin
    xs   = x_i >>> SHIFT;
    ys   = y_i >>> SHIFT;
    step = atan_lut(ATAN_IDX_W'(SHIFT));
    if (!y_i[DW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + step;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ld) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

@@ design/pdp_gain.sv @@
module pdp_gain import pdp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DW          = COORD_WIDTH_DEF + 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    ld,
  input  pdp_ctl_t                      ctl_i,
  input  logic signed [DW-1:0]          x_i,
  input  logic [Z_WIDTH-1:0]            z_i,
  output logic                          vld_a_o,
  output pdp_ctl_t                      ctl_o,
  output logic [COORD_WIDTH:0]          magnitude,
  output logic signed [ANGLE_WIDTH-1:0] direction
);

  localparam int XW    = (DW - 1 > LO_WIDTH) ? DW - 1 : LO_WIDTH + 1;
  localparam int HW    = XW - LO_WIDTH;
  localparam int PW_LO = LO_WIDTH + GAIN_WIDTH;
  localparam int PW_HI = HW + GAIN_WIDTH;
  localparam int QW    = PW_LO + 1 - LO_WIDTH;
  localparam int TW    = HW + QW;
  localparam int MW    = TW - FIN_SHIFT;

  pdp_ctl_t                      ctl_a_r, ctl_b_r;
  logic [XW-1:0]                 xf;
  logic [PW_LO-1:0]              lo_prod_nxt, lo_prod_r;
  logic [PW_HI-1:0]              hi_prod_nxt, hi_prod_r;
  logic [Z_WIDTH-1:0]            zr;
  logic [ANGLE_WIDTH-1:0]        dir_a_r, dir_a_nxt;
  logic [PW_LO:0]                lo_rnd;
  logic [TW-1:0]                 total;
  logic [MW-1:0]                 mag_full;
  logic [COORD_WIDTH:0]          mag_nxt, mag_r;
  logic [ANGLE_WIDTH-1:0]        dir_b_nxt, dir_b_r;

  // Stage A: the gain multiply, split into two partial products.
  always_comb begin
    xf          = x_i[DW-1] ? '0 : XW'(unsigned'(x_i[DW-2:0]));
    lo_prod_nxt = PW_LO'(xf[LO_WIDTH-1:0]) * PW_LO'(INV_GAIN);
    hi_prod_nxt = PW_HI'(xf[XW-1:LO_WIDTH]) * PW_HI'(INV_GAIN);
    zr          = z_i + DIR_ROUND;
    dir_a_nxt   = zr[Z_WIDTH-1:Z_WIDTH-ANGLE_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (ld[0]) begin
      ctl_a_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lo_prod_r <= lo_prod_nxt;
      hi_prod_r <= hi_prod_nxt;
      dir_a_r   <= dir_a_nxt;
    end
  end

  // Stage B: combine with round-half-up, saturate, and force the zero case.
  always_comb begin
    lo_rnd   = {1'b0, lo_prod_r} + ((PW_LO+1)'(1) << RND_SHIFT);
    total    = TW'(hi_prod_r) + TW'(lo_rnd[PW_LO:LO_WIDTH]);
    mag_full = total[TW-1:FIN_SHIFT];
    if (|mag_full[MW-1:COORD_WIDTH+1]) begin
      mag_nxt = '1;
    end else begin
      mag_nxt = mag_full[COORD_WIDTH:0];
    end
    dir_b_nxt = dir_a_r;
    if (ctl_a_r.zero) begin
      mag_nxt   = '0;
      dir_b_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (ld[1]) begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      mag_r   <= mag_nxt;
      dir_b_r <= dir_b_nxt;
    end
  end

  assign vld_a_o   = ctl_a_r.valid;
  assign ctl_o     = ctl_b_r;
  assign magnitude = mag_r;
  assign direction = signed'(dir_b_r);

endmodule

@@ design/point_difference_to_polar.sv @@
// Distance and direction from the second point to the first. Each item is taken
// through a pipeline of ITERATIONS + 4 register stages (ITERATIONS is capped at
// 24): two stages form the difference and fold it into the right half plane, one
// stage per CORDIC micro-rotation, and two stages apply the inverse gain and round.
// One item can enter every cycle unless the result side stalls a full pipeline;
// the number of stages is set by the number of micro-rotations, one per stage.
// Each stage holds its item when the next one is full and does not load, so a
// stall on the result side fills bubbles first and only then pushes back on the
// input. A zero difference gives magnitude 0 and direction 0; direction uses 32768 for pi.
module point_difference_to_polar import pdp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ITERATIONS  = ITERATIONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pdp_in_if.sink        in_if,
  pdp_out_if.source     out_if
);

  localparam int DW     = COORD_WIDTH + 11;
  localparam int NSTEP  = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;
  localparam int STAGES = NSTEP + 4;

  logic [STAGES:0]      ld;
  logic [STAGES-1:0]    vld;
  logic                 vld0, vld_a;
  pdp_ctl_t             cc [0:NSTEP];
  logic signed [DW-1:0] cx [0:NSTEP];
  logic signed [DW-1:0] cy [0:NSTEP];
  logic [Z_WIDTH-1:0]   cz [0:NSTEP];
  pdp_ctl_t             out_ctl;

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    ld[STAGES] = out_if.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  always_comb begin
    vld[0] = vld0;
    for (int k = 0; k <= NSTEP; k++) begin
      vld[k+1] = cc[k].valid;
    end
    vld[NSTEP+2] = vld_a;
    vld[NSTEP+3] = out_ctl.valid;
  end

  assign in_if.ready = ld[0];

  pdp_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .DW          (DW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld[1:0]),
    .in_valid (in_if.valid),
    .first_x  (in_if.first_x),
    .first_y  (in_if.first_y),
    .second_x (in_if.second_x),
    .second_y (in_if.second_y),
    .vld0_o   (vld0),
    .ctl_o    (cc[0]),
    .x_o      (cx[0]),
    .y_o      (cy[0]),
    .z_o      (cz[0])
  );

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    pdp_cordic_stage #(
      .DW    (DW),
      .SHIFT (g)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ld    (ld[g+2]),
      .ctl_i (cc[g]),
      .x_i   (cx[g]),
      .y_i   (cy[g]),
      .z_i   (cz[g]),
      .ctl_o (cc[g+1]),
      .x_o   (cx[g+1]),
      .y_o   (cy[g+1]),
      .z_o   (cz[g+1])
    );
  end

  pdp_gain #(
    .COORD_WIDTH (COORD_WIDTH),
    .DW          (DW)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld[NSTEP+3:NSTEP+2]),
    .ctl_i     (cc[NSTEP]),
    .x_i       (cx[NSTEP]),
    .z_i       (cz[NSTEP]),
    .vld_a_o   (vld_a),
    .ctl_o     (out_ctl),
    .magnitude (out_if.magnitude),
    .direction (out_if.direction)
  );

  assign out_if.valid = out_ctl.valid;

endmodule

@@ design/pdp_checker.sv @@
module pdp_checker import pdp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DEPTH       = ITERATIONS_DEF + 4
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [COORD_WIDTH:0]          magnitude,
  input logic signed [ANGLE_WIDTH-1:0] direction
);

  localparam int CW = $clog2(DEPTH + 2);

  logic [CW-1:0] cnt_r, cnt_nxt;

  // Items accepted but not yet delivered.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) begin
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(direction))
    else $error("stalled result changed");

  a_no_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while the result side can move");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid |-> cnt_r != '0) and (cnt_r <= CW'(DEPTH)))
    else $error("result without a pending item, or too many items in flight");

  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> magnitude != '1)
    else $error("magnitude reached saturation");

endmodule

bind point_difference_to_polar pdp_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .DEPTH       (STAGES)
) u_pdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .magnitude (out_if.magnitude),
  .direction (out_if.direction)
);

@@ bench/point_difference_to_polar_test.sv @@
module point_difference_to_polar_test;
  import pdp_pkg::*;

  localparam int CW         = COORD_WIDTH_DEF;
  localparam int STEPS      = (ITERATIONS_DEF > 24) ? 24 : ITERATIONS_DEF;
  localparam int FRAC_EXTRA = 8;
  localparam int RANDOM_PAIRS = 650;
  localparam int CYCLE_LIMIT  = 60000;
  localparam int HOLD_CYCLES  = 150;

  localparam logic signed [CW-1:0] MAXC = 16'sh7FFF;
  localparam logic signed [CW-1:0] MINC = 16'sh8000;

  // Inverse gain of the rotation sequence in Q30.
  localparam bit [63:0] GAIN_Q30 = 64'd652032874;

  // atan(2^-k) with 2^31 standing for pi.
  localparam bit [31:0] ATAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
  } pair_t;

  typedef struct packed {
    logic        [CW:0]          magnitude;
    logic signed [ANGLE_WIDTH-1:0] direction;
  } polar_t;

  typedef struct packed {
    pair_t  item;
    logic   typed;
    polar_t want;
  } pair_row_t;

  // A typed result is only given where the points coincide.
  localparam pair_row_t DIRECTED [20] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{17'd0, 16'sd0}},
    '{'{MAXC, MAXC, MAXC, MAXC}, 1'b1, '{17'd0, 16'sd0}},
    '{'{MINC, MINC, MINC, MINC}, 1'b1, '{17'd0, 16'sd0}},
    '{'{MAXC, MINC, MAXC, MINC}, 1'b1, '{17'd0, 16'sd0}},
    '{'{16'sd4096, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd4096, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd4096, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, -16'sd4096, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{MAXC, MAXC, MINC, MINC}, 1'b0, '0},
    '{'{MINC, MINC, MAXC, MAXC}, 1'b0, '0},
    '{'{MAXC, MINC, MINC, MAXC}, 1'b0, '0},
    '{'{MINC, MAXC, MAXC, MINC}, 1'b0, '0},
    '{'{MAXC, 16'sd0, MINC, 16'sd0}, 1'b0, '0},
    '{'{MINC, 16'sd0, MAXC, 16'sd0}, 1'b0, '0},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1'b0, '0},
    '{'{16'sd3000, 16'sd4000, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd100, -16'sd200, -16'sd300, 16'sd50}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, MINC, 16'sd0}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  pdp_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  pdp_out_if #(.COORD_WIDTH(CW)) out_ch ();

  point_difference_to_polar uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  polar_t awaited_polar[$];
  int     pairs_sent   = 0;
  int     results_seen = 0;
  int     failures     = 0;
  int     cycle_count  = 0;
  bit     in_gaps      = 1'b1;
  bit     squeezed     = 1'b0;

  // Vectoring rotations on the point difference, then the gain multiply.
  function automatic polar_t polar_of(input pair_t p);
    longint    dx, dy, x, y, t, xs, ys;
    bit [31:0] z;
    bit [63:0] xf, hi, lo, mag;
    polar_t    r;
    dx = longint'(p.first_x) - longint'(p.second_x);
    dy = longint'(p.first_y) - longint'(p.second_y);
    if (dx == 0 && dy == 0) begin
      return '0;
    end
    x = dx * (64'sd1 <<< FRAC_EXTRA);
    y = dy * (64'sd1 <<< FRAC_EXTRA);
    z = 32'd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 32'h4000_0000;
      end else begin
        x = -y;
        y = t;
        z = 32'hC000_0000;
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[k];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[k];
      end
    end
    xf  = (x < 0) ? 64'd0 : 64'(x);
    hi  = xf >> 22;
    lo  = xf & 64'h3F_FFFF;
    mag = (hi * GAIN_Q30 + ((lo * GAIN_Q30 + (64'd1 << 37)) >> 22)) >> 16;
    if (mag > 64'h1_FFFF) begin
      mag = 64'h1_FFFF;
    end
    z = z + 32'h0000_8000;
    r.magnitude = mag[CW:0];
    r.direction = z[31:16];
    return r;
  endfunction

  function automatic logic signed [CW-1:0] corner_coord();
    logic signed [CW-1:0] c;
    case ($urandom_range(3))
      0:       c = MAXC;
      1:       c = MINC;
      2:       c = '0;
      default: c = CW'($urandom);
    endcase
    return c;
  endfunction

  // Mostly wide random pairs, plus near neighbours, origin-based vectors,
  // coincident points and corner values.
  function automatic pair_t random_pair();
    pair_t p;
    int    pick;
    pick = $urandom_range(99);
    p = {$urandom, $urandom};
    if (pick >= 55 && pick < 75) begin
      p.second_x = p.first_x + CW'(int'($urandom_range(600)) - 300);
      p.second_y = p.first_y + CW'(int'($urandom_range(600)) - 300);
    end else if (pick >= 75 && pick < 85) begin
      p.second_x = '0;
      p.second_y = '0;
    end else if (pick >= 85 && pick < 92) begin
      p.second_x = p.first_x;
      p.second_y = p.first_y;
    end else if (pick >= 92) begin
      p.first_x  = corner_coord();
      p.first_y  = corner_coord();
      p.second_x = corner_coord();
      p.second_y = corner_coord();
    end
    return p;
  endfunction

  task automatic send_pair(input pair_t p, input polar_t want);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 24) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.first_x  = p.first_x;
    in_ch.first_y  = p.first_y;
    in_ch.second_x = p.second_x;
    in_ch.second_y = p.second_y;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pairs_sent++;
    awaited_polar.push_back(want);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pair_t p;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.first_x  = '0;
    in_ch.first_y  = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (DIRECTED[k]) begin
      send_pair(DIRECTED[k].item,
                DIRECTED[k].typed ? DIRECTED[k].want : polar_of(DIRECTED[k].item));
    end
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      in_gaps = !(n >= 400 && n < 550);
      p = random_pair();
      send_pair(p, polar_of(p));
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (awaited_polar.size() == 0);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off that fills the
  // pipeline while items keep coming, and a stretch with ready held high.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!squeezed && pairs_sent >= 150) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (results_seen >= 300 && results_seen < 450) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    polar_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (awaited_polar.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("result with nothing outstanding: magnitude %0d direction %0d",
                   out_ch.magnitude, out_ch.direction);
        end
      end else begin
        want = awaited_polar.pop_front();
        if (out_ch.magnitude !== want.magnitude || out_ch.direction !== want.direction) begin
          failures++;
          if (failures <= 10) begin
            $display("result %0d: magnitude %0d (want %0d) direction %0d (want %0d)",
                     results_seen, out_ch.magnitude, want.magnitude,
                     out_ch.direction, want.direction);
          end
        end
      end
    end
  end

endmodule

@@ point_difference_to_polar.f @@
design/pdp_pkg.sv
design/pdp_if.sv
design/pdp_front.sv
design/pdp_cordic_stage.sv
design/pdp_gain.sv
design/point_difference_to_polar.sv
design/pdp_checker.sv
bench/point_difference_to_polar_test.sv
